@@ rtl/acg_pkg.sv @@
// Package: shared types, constants and state codes for the connectivity grouping block.
package acg_pkg;

    localparam int MAX_DIM_DEF   = 16;
    localparam int MAX_CELLS_DEF = 4096;

    localparam int IDX_W  = 12;
    localparam int CNT_W  = 13;
    localparam int LBL_W  = 14;
    localparam int SIZE_W = 5;

    localparam logic [CNT_W-1:0] CNT_MAX = 13'd8191;

    localparam logic [LBL_W-1:0] LBL_ABSENT    = 14'd0;
    localparam logic [LBL_W-1:0] LBL_DESTROYED = 14'd1;
    localparam logic [LBL_W-1:0] LBL_ANCHORED  = 14'd2;
    localparam logic [LBL_W-1:0] LBL_PENDING   = 14'h3FFF;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_RUN   = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CFG_SIZE_X = 2'd0,
        CFG_SIZE_Y = 2'd1,
        CFG_SIZE_Z = 2'd2,
        CFG_UNUSED = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT_RD,   // sweep: read flags
        ST_INIT_WR,   // sweep: write first label
        ST_POP,       // take queue head
        ST_COORD,     // split coordinates
        ST_NB_RD,     // read neighbor label
        ST_NB_CHK,    // claim neighbor if pending
        ST_SCAN_RD,   // group scan: read label
        ST_SCAN_CHK,  // group scan: open group
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [IDX_W-1:0] cell_index;
        logic             cell_exists;
        logic             cell_anchor;
        logic             cell_destroyed;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       cell_class;
        logic [CNT_W-1:0] group_number;
        logic [CNT_W-1:0] group_count;
        logic [CNT_W-1:0] detached_count;
    } t_out_item;

    // Memory request from the walk engine.
    typedef struct packed {
        logic             lbl_re;
        logic             lbl_we;
        logic [IDX_W-1:0] lbl_addr;
        logic [LBL_W-1:0] lbl_wdata;
    } t_lbl_req;

endpackage

@@ rtl/anchor_connectivity_grouping.sv @@
// Top level: flag and label memories, request handling and result strobe.
//   channel  | ports                                   | handshake
//   request  | i_start, i_req (t_in_item), o_busy      | taken when i_start && !o_busy
//   result   | o_done, o_result (t_out_item)           | one-cycle strobe, no stall
//   config   | i_cfg_we, i_cfg_idx, i_cfg_wdata        | written when i_cfg_we
// Writes and reads answer in the cycle after transfer, one per cycle while not busy.
// A run sweeps all MAX_CELLS entries, then pops each queued cell, splits its coordinates
// and checks each face, and scans cells for pending ones to open groups; label port bounds it.
// Reset clears the flag store by a pass over all MAX_CELLS entries, busy throughout.
module anchor_connectivity_grouping #(
    parameter int MAX_DIM   = acg_pkg::MAX_DIM_DEF,
    parameter int MAX_CELLS = acg_pkg::MAX_CELLS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  acg_pkg::t_in_item     i_req,
    output logic                  o_done,
    output acg_pkg::t_out_item    o_result,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [acg_pkg::SIZE_W-1:0] i_cfg_wdata
);
    import acg_pkg::*;

    localparam int AW = $clog2(MAX_CELLS);

    logic [2:0]       cell_flags [MAX_CELLS];
    logic [LBL_W-1:0] cell_label [MAX_CELLS];

    logic [SIZE_W-1:0] r_sx, r_sy, r_sz;
    logic [AW:0]       r_clr;
    logic              r_clearing;
    logic              r_running;
    logic              r_rd_pend, r_ack;
    logic              r_lbl_valid;  // labels hold a run's result
    logic [CNT_W-1:0]  r_groups, r_det;
    logic [2:0]        r_flag_rdata;
    logic [LBL_W-1:0]  r_lbl_rdata;

    logic              accept, go;
    logic              w_flag_re, w_done;
    logic [IDX_W-1:0]  w_flag_addr;
    t_lbl_req          w_lbl;
    logic [CNT_W-1:0]  w_groups, w_det;
    logic              idx_ok;

    assign o_busy = r_clearing || r_running;
    assign accept = i_start && !o_busy;
    assign go     = accept && t_req'(i_req.req_type) == REQ_RUN;
    assign idx_ok = {1'b0, i_req.cell_index} < 13'(MAX_CELLS);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= SIZE_W'(16);
            r_sy <= SIZE_W'(16);
            r_sz <= SIZE_W'(16);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SIZE_X: r_sx <= i_cfg_wdata;
                CFG_SIZE_Y: r_sy <= i_cfg_wdata;
                CFG_SIZE_Z: r_sz <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Flag store: clearing pass, request writes, sweep reads.
    always_ff @(posedge i_clk) begin
        if (r_clearing) cell_flags[r_clr[AW-1:0]] <= 3'b000;
        else if (accept && t_req'(i_req.req_type) == REQ_WRITE && idx_ok)
            cell_flags[i_req.cell_index[AW-1:0]] <=
                {i_req.cell_destroyed, i_req.cell_anchor, i_req.cell_exists};
        if (w_flag_re) r_flag_rdata <= cell_flags[w_flag_addr[AW-1:0]];
    end

    // Label store: walk engine owns it while running, reads otherwise.
    always_ff @(posedge i_clk) begin
        if (w_lbl.lbl_we) cell_label[w_lbl.lbl_addr[AW-1:0]] <= w_lbl.lbl_wdata;
        if (r_running) begin
            if (w_lbl.lbl_re) r_lbl_rdata <= cell_label[w_lbl.lbl_addr[AW-1:0]];
        end else if (accept) begin
            r_lbl_rdata <= cell_label[i_req.cell_index[AW-1:0]];
        end
    end

    // Control and totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr       <= '0;
            r_running   <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_ack       <= 1'b0;
            r_lbl_valid <= 1'b0;
            r_groups    <= '0;
            r_det       <= '0;
        end else begin
            r_ack     <= 1'b0;
            r_rd_pend <= 1'b0;
            if (r_clearing) begin
                r_clr <= r_clr + (AW+1)'(1);
                if (r_clr == (AW+1)'(MAX_CELLS - 1)) r_clearing <= 1'b0;
            end
            if (go) r_running <= 1'b1;
            else if (accept) begin
                r_ack     <= 1'b1;
                r_rd_pend <= t_req'(i_req.req_type) == REQ_READ && idx_ok;
            end
            if (w_done) begin
                r_running   <= 1'b0;
                r_ack       <= 1'b1;
                r_lbl_valid <= 1'b1;
                r_groups    <= w_groups;
                r_det       <= w_det;
            end
        end
    end

    // Build the result.
    always_comb begin
        o_done   = r_ack;
        o_result = '0;
        o_result.group_count    = r_groups;
        o_result.detached_count = r_det;
        if (r_rd_pend && r_lbl_valid) begin
            if (r_lbl_rdata <= LBL_ANCHORED) o_result.cell_class = r_lbl_rdata[1:0];
            else begin
                o_result.cell_class   = 2'd3;
                o_result.group_number = CNT_W'(r_lbl_rdata - 14'd2);
            end
        end
    end

    acg_walk #(.MAX_DIM(MAX_DIM), .MAX_CELLS(MAX_CELLS)) u_walk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (go),
        .i_sx         (r_sx),
        .i_sy         (r_sy),
        .i_sz         (r_sz),
        .o_flag_re    (w_flag_re),
        .o_flag_addr  (w_flag_addr),
        .i_flag_rdata (r_flag_rdata),
        .o_lbl        (w_lbl),
        .i_lbl_rdata  (r_lbl_rdata),
        .o_done       (w_done),
        .o_groups     (w_groups),
        .o_detached   (w_det)
    );

    // No request taken while clearing or running.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> !accept) else $error("transfer while busy");
    // Every accepted non-run request answers next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !go) |=> o_done) else $error("missing answer");
    // A run finishing ends the busy phase.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> !r_running) else $error("run did not end");
endmodule

@@ rtl/acg_walk.sv @@
// Walk engine: initial sweep, flood fill from anchors and detached grouping.
module acg_walk #(
    parameter int MAX_DIM   = acg_pkg::MAX_DIM_DEF,
    parameter int MAX_CELLS = acg_pkg::MAX_CELLS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [acg_pkg::SIZE_W-1:0]    i_sx,
    input  logic [acg_pkg::SIZE_W-1:0]    i_sy,
    input  logic [acg_pkg::SIZE_W-1:0]    i_sz,
    output logic                          o_flag_re,
    output logic [acg_pkg::IDX_W-1:0]     o_flag_addr,
    input  logic [2:0]                    i_flag_rdata,
    output acg_pkg::t_lbl_req             o_lbl,
    input  logic [acg_pkg::LBL_W-1:0]     i_lbl_rdata,
    output logic                          o_done,
    output logic [acg_pkg::CNT_W-1:0]     o_groups,
    output logic [acg_pkg::CNT_W-1:0]     o_detached
);
    import acg_pkg::*;

    localparam int AW   = $clog2(MAX_CELLS);
    localparam int QW   = AW + 1;
    localparam int CW   = $clog2(MAX_DIM);
    localparam int QE_W = IDX_W + 3 * CW;

    t_state r_state, n_state;

    // Queue memory: one write and one read port, registered read.
    // Each entry carries the cell index and its x, y, z coordinates.
    logic [QE_W-1:0]  walk_queue [MAX_CELLS];
    logic             q_we;
    logic [AW-1:0]    q_waddr;
    logic [QE_W-1:0]  q_wdata;
    logic [AW-1:0]    q_raddr;
    logic [QE_W-1:0]  r_q_rdata;

    logic [QW-1:0]    r_head, r_tail;
    logic [QW-1:0]    r_i;         // sweep / scan counter
    logic [QW-1:0]    r_n;         // cells in use
    logic [12:0]      r_plane;
    logic [IDX_W-1:0] r_c;
    logic [6:0]       r_x, r_y, r_z;
    logic [6:0]       r_cx, r_cy, r_cz;  // coordinates of r_i for the sweep and scan
    logic [2:0]       r_dir;
    logic [IDX_W+1:0] r_nb;
    logic             r_nb_ok;
    logic [LBL_W-1:0] r_mark;
    logic             r_grouping;
    logic [CNT_W-1:0] r_groups, r_det;

    logic [6:0] sx, sy, sz;
    logic [19:0] n_full;

    // Clamp sizes to 1..MAX_DIM.
    function automatic logic [6:0] clamp(input logic [SIZE_W-1:0] v);
        logic [6:0] r;
        r = {2'b00, v};
        if (r == 7'd0) r = 7'd1;
        if (r > 7'(MAX_DIM)) r = 7'(MAX_DIM);
        return r;
    endfunction

    assign sx = clamp(i_sx);
    assign sy = clamp(i_sy);
    assign sz = clamp(i_sz);
    assign n_full = 20'(sx) * 20'(sy) * 20'(sz);

    // Advance the sweep / scan coordinates by one cell.
    logic [6:0] cx_nx, cy_nx, cz_nx;
    always_comb begin
        cx_nx = r_cx + 7'd1;
        cy_nx = r_cy;
        cz_nx = r_cz;
        if (cx_nx >= sx) begin
            cx_nx = '0;
            cy_nx = r_cy + 7'd1;
            if (cy_nx >= sy) begin
                cy_nx = '0;
                cz_nx = r_cz + 7'd1;
            end
        end
    end

    // Neighbor candidate for the current direction.
    logic [IDX_W+1:0] nb_c;
    logic             nb_v;
    logic [6:0]       nb_x, nb_y, nb_z;
    always_comb begin
        nb_c = '0;
        nb_v = 1'b0;
        nb_x = r_x;
        nb_y = r_y;
        nb_z = r_z;
        unique case (r_dir)
            3'd0: begin
                nb_v = r_x != 7'd0;       nb_c = 14'(r_c) - 14'd1;     nb_x = r_x - 7'd1;
            end
            3'd1: begin
                nb_v = (r_x + 7'd1) < sx; nb_c = 14'(r_c) + 14'd1;     nb_x = r_x + 7'd1;
            end
            3'd2: begin
                nb_v = r_y != 7'd0;       nb_c = 14'(r_c) - 14'(sx);   nb_y = r_y - 7'd1;
            end
            3'd3: begin
                nb_v = (r_y + 7'd1) < sy; nb_c = 14'(r_c) + 14'(sx);   nb_y = r_y + 7'd1;
            end
            3'd4: begin
                nb_v = r_z != 7'd0;       nb_c = 14'(r_c) - 14'(r_plane); nb_z = r_z - 7'd1;
            end
            3'd5: begin
                nb_v = (r_z + 7'd1) < sz; nb_c = 14'(r_c) + 14'(r_plane); nb_z = r_z + 7'd1;
            end
            default: begin nb_v = 1'b0; nb_c = '0; end
        endcase
        if (nb_c >= 14'(r_n)) nb_v = 1'b0;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (i_go) n_state = ST_INIT_RD;
            ST_INIT_RD:  n_state = ST_INIT_WR;
            ST_INIT_WR:  n_state = (r_i == QW'(MAX_CELLS - 1)) ? ST_POP : ST_INIT_RD;
            ST_POP: begin
                if (r_head != r_tail) n_state = ST_COORD;
                else if (r_grouping && r_i >= r_n) n_state = ST_DONE;
                else n_state = ST_SCAN_RD;
            end
            ST_COORD:    n_state = ST_NB_RD;
            ST_NB_RD:    n_state = ST_NB_CHK;
            ST_NB_CHK:   n_state = (r_dir == 3'd5) ? ST_POP : ST_NB_RD;
            ST_SCAN_RD:  n_state = (r_i >= r_n) ? ST_DONE : ST_SCAN_CHK;
            ST_SCAN_CHK: n_state = (i_lbl_rdata == LBL_PENDING) ? ST_POP : ST_SCAN_RD;
            ST_DONE:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Memory controls.
    always_comb begin
        o_flag_re   = 1'b0;
        o_flag_addr = r_i[IDX_W-1:0];
        o_lbl       = '0;
        q_we        = 1'b0;
        q_waddr     = r_tail[AW-1:0];
        q_wdata     = {r_cz[CW-1:0], r_cy[CW-1:0], r_cx[CW-1:0], r_i[IDX_W-1:0]};
        q_raddr     = r_head[AW-1:0];
        unique case (r_state)
            ST_INIT_RD: o_flag_re = 1'b1;
            ST_INIT_WR: begin
                o_lbl.lbl_we   = 1'b1;
                o_lbl.lbl_addr = r_i[IDX_W-1:0];
                if (r_i >= r_n || !i_flag_rdata[0]) o_lbl.lbl_wdata = LBL_ABSENT;
                else if (i_flag_rdata[2])          o_lbl.lbl_wdata = LBL_DESTROYED;
                else if (i_flag_rdata[1]) begin
                    o_lbl.lbl_wdata = LBL_ANCHORED;
                    q_we = 1'b1;
                end else o_lbl.lbl_wdata = LBL_PENDING;
            end
            ST_NB_RD: begin
                o_lbl.lbl_re   = nb_v;
                o_lbl.lbl_addr = nb_c[IDX_W-1:0];
            end
            ST_NB_CHK: begin
                if (r_nb_ok && i_lbl_rdata == LBL_PENDING &&
                    r_tail < QW'(MAX_CELLS)) begin
                    o_lbl.lbl_we    = 1'b1;
                    o_lbl.lbl_addr  = r_nb[IDX_W-1:0];
                    o_lbl.lbl_wdata = r_mark;
                    q_we    = 1'b1;
                    q_wdata = {nb_z[CW-1:0], nb_y[CW-1:0], nb_x[CW-1:0], r_nb[IDX_W-1:0]};
                end
            end
            ST_SCAN_RD: begin
                o_lbl.lbl_re   = r_i < r_n;
                o_lbl.lbl_addr = r_i[IDX_W-1:0];
            end
            ST_SCAN_CHK: begin
                if (i_lbl_rdata == LBL_PENDING) begin
                    o_lbl.lbl_we    = 1'b1;
                    o_lbl.lbl_addr  = r_i[IDX_W-1:0];
                    o_lbl.lbl_wdata = 14'(((r_groups < CNT_MAX) ? r_groups + 13'd1
                                                                : r_groups)) + 14'd2;
                    q_we    = 1'b1;
                    q_waddr = '0;
                end
            end
            default: ;
        endcase
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (q_we) walk_queue[q_waddr] <= q_wdata;
        r_q_rdata <= walk_queue[q_raddr];
    end

    // Walk registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_head     <= '0;
            r_tail     <= '0;
            r_groups   <= '0;
            r_det      <= '0;
            r_grouping <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: if (i_go) begin
                    r_i        <= '0;
                    r_cx       <= '0;
                    r_cy       <= '0;
                    r_cz       <= '0;
                    r_head     <= '0;
                    r_tail     <= '0;
                    r_groups   <= '0;
                    r_det      <= '0;
                    r_grouping <= 1'b0;
                    r_mark     <= LBL_ANCHORED;
                    r_plane    <= 13'(sx) * 13'(sy);
                    r_n        <= (n_full > 20'(MAX_CELLS)) ? QW'(MAX_CELLS) : QW'(n_full);
                end
                ST_INIT_WR: begin
                    if (q_we) r_tail <= r_tail + QW'(1);
                    if (r_i == QW'(MAX_CELLS - 1)) begin
                        r_i  <= '0;
                        r_cx <= '0;
                        r_cy <= '0;
                        r_cz <= '0;
                    end else begin
                        r_i  <= r_i + QW'(1);
                        r_cx <= cx_nx;
                        r_cy <= cy_nx;
                        r_cz <= cz_nx;
                    end
                end
                ST_POP: begin
                    if (r_head != r_tail) r_head <= r_head + QW'(1);
                    else if (r_grouping) begin
                        r_i  <= r_i + QW'(1);
                        r_cx <= cx_nx;
                        r_cy <= cy_nx;
                        r_cz <= cz_nx;
                    end
                end
                ST_COORD: begin
                    r_c   <= r_q_rdata[IDX_W-1:0];
                    r_dir <= 3'd0;
                    r_x   <= 7'(r_q_rdata[IDX_W +: CW]);
                    r_y   <= 7'(r_q_rdata[IDX_W+CW +: CW]);
                    r_z   <= 7'(r_q_rdata[IDX_W+2*CW +: CW]);
                end
                ST_NB_RD: begin
                    r_nb    <= nb_c;
                    r_nb_ok <= nb_v;
                end
                ST_NB_CHK: begin
                    r_dir <= r_dir + 3'd1;
                    if (q_we) begin
                        r_tail <= r_tail + QW'(1);
                        if (r_grouping && r_det < CNT_MAX) r_det <= r_det + 13'd1;
                    end
                end
                ST_SCAN_RD: if (r_i >= r_n) r_grouping <= 1'b1;
                ST_SCAN_CHK: begin
                    r_grouping <= 1'b1;
                    if (q_we) begin
                        if (r_groups < CNT_MAX) r_groups <= r_groups + 13'd1;
                        r_mark <= o_lbl.lbl_wdata;
                        r_head <= '0;
                        r_tail <= QW'(1);
                        if (r_det < CNT_MAX) r_det <= r_det + 13'd1;
                    end else begin
                        r_i  <= r_i + QW'(1);
                        r_cx <= cx_nx;
                        r_cy <= cy_nx;
                        r_cz <= cz_nx;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_done     = r_state == ST_DONE;
    assign o_groups   = r_groups;
    assign o_detached = r_det;

    // Queue never overflows its store.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail <= QW'(MAX_CELLS)) else $error("walk queue overrun");
    // Head never passes tail.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail) else $error("walk head passed tail");
    // A claim writes the label and queue together.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NB_CHK && q_we) |-> o_lbl.lbl_we) else $error("claim split");
endmodule
